// ===== rtl/utf7sd_pkg.sv =====
// utf7sd_pkg: types, character constants and the base64 sextet lookup for the
// UTF-7 stream decoder. No dependencies.
package utf7sd_pkg;

	typedef enum logic [1:0] {
		MODE_DIRECT,
		MODE_PLUS,
		MODE_SHIFT,
		MODE_ERROR
	} mode_t;

	typedef enum logic [2:0] {
		ST_CHAR,
		ST_END,
		ST_NONASCII,
		ST_INCOMPLETE,
		ST_HIGH_NO_LOW,
		ST_LONE_LOW,
		ST_MALFORMED
	} status_t;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CP_W     = 21;
	localparam int unsigned UNIT_W   = 16;
	localparam int unsigned BUF_W    = 14;
	localparam int unsigned BCNT_W   = 4;
	localparam int unsigned SEXTET_W = 6;

	localparam logic [BYTE_W-1:0] CH_PLUS     = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS    = 8'h2D;
	localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;

	localparam logic [UNIT_W-1:0] HI_SURR_MIN = 16'hD800;
	localparam logic [UNIT_W-1:0] HI_SURR_MAX = 16'hDBFF;
	localparam logic [UNIT_W-1:0] LO_SURR_MIN = 16'hDC00;
	localparam logic [UNIT_W-1:0] LO_SURR_MAX = 16'hDFFF;
	localparam logic [CP_W-1:0]   SUPP_BASE   = 21'h10000;

	typedef struct packed {
		mode_t             mode;
		logic [BUF_W-1:0]  bit_buffer;
		logic [BCNT_W-1:0] bit_count;
		logic [1:0]        sextet_count;
		logic [UNIT_W-1:0] high_surrogate;
	} state_t;

	localparam state_t STATE_RESET = '{
		mode:           MODE_DIRECT,
		bit_buffer:     '0,
		bit_count:      '0,
		sextet_count:   '0,
		high_surrogate: '0
	};

	typedef struct packed {
		logic            valid;
		logic [CP_W-1:0] code_point;
		status_t         status;
	} result_t;

	typedef struct packed {
		logic                ok;
		logic [SEXTET_W-1:0] val;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [BYTE_W-1:0] b);
		sextet_t s;
		s.ok  = 1'b1;
		s.val = '0;
		if (b >= 8'h41 && b <= 8'h5A) begin
			s.val = SEXTET_W'(b - 8'h41);
		end else if (b >= 8'h61 && b <= 8'h7A) begin
			s.val = SEXTET_W'(b - 8'h61 + 8'd26);
		end else if (b >= 8'h30 && b <= 8'h39) begin
			s.val = SEXTET_W'(b - 8'h30 + 8'd52);
		end else if (b == CH_PLUS) begin
			s.val = 6'd62;
		end else if (b == 8'h2F) begin
			s.val = 6'd63;
		end else begin
			s.ok = 1'b0;
		end
		return s;
	endfunction

endpackage

// ===== rtl/utf7sd_step.sv =====
// utf7sd_step: next-state and result logic for one transaction of the decoder.
// Purely combinational; depends on utf7sd_pkg.
module utf7sd_step (
	input  utf7sd_pkg::state_t                      cur,
	input  logic [utf7sd_pkg::BYTE_W-1:0]           text_byte,
	input  logic                                    end_of_text,
	output utf7sd_pkg::state_t                      nxt,
	output utf7sd_pkg::result_t                     res
);

	utf7sd_pkg::sextet_t                  sx;
	utf7sd_pkg::state_t                   base;
	logic                                 run_bad;
	logic                                 cur_bad;
	logic [utf7sd_pkg::BUF_W+5:0]         acc;
	logic [utf7sd_pkg::BCNT_W:0]          cnt6;
	logic                                 full;
	logic [utf7sd_pkg::BCNT_W-1:0]        rem;
	logic [utf7sd_pkg::BUF_W+5:0]         acc_sh;
	logic [utf7sd_pkg::UNIT_W-1:0]        unit;
	logic [utf7sd_pkg::BUF_W-1:0]         mask;
	logic                                 shf_go;
	logic                                 dir_go;

	assign sx = utf7sd_pkg::sextet_of(text_byte);

	// a run opened from after-plus starts empty
	always_comb begin
		base = cur;
		if (cur.mode == utf7sd_pkg::MODE_PLUS) begin
			base.bit_buffer     = '0;
			base.bit_count      = '0;
			base.sextet_count   = '0;
			base.high_surrogate = '0;
		end
	end

	assign run_bad = (base.sextet_count < 2'd3) || (base.bit_count > 4'd4) ||
		((base.bit_count != '0) && (base.bit_buffer != '0)) ||
		(base.high_surrogate != '0);
	assign cur_bad = (cur.sextet_count < 2'd3) || (cur.bit_count > 4'd4) ||
		((cur.bit_count != '0) && (cur.bit_buffer != '0)) ||
		(cur.high_surrogate != '0);

	assign acc    = {base.bit_buffer, sx.val};
	assign cnt6   = {1'b0, base.bit_count} + 5'd6;
	assign full   = cnt6 >= 5'd16;
	assign rem    = utf7sd_pkg::BCNT_W'(cnt6 - 5'd16);
	assign acc_sh = acc >> rem;
	assign unit   = acc_sh[utf7sd_pkg::UNIT_W-1:0];
	assign mask   = (utf7sd_pkg::BUF_W'(1) << rem) - utf7sd_pkg::BUF_W'(1);

	always_comb begin
		nxt            = cur;
		res.valid      = 1'b0;
		res.code_point = '0;
		res.status     = utf7sd_pkg::ST_CHAR;
		shf_go         = 1'b0;
		dir_go         = 1'b0;
		if (end_of_text) begin
			nxt = utf7sd_pkg::STATE_RESET;
			unique case (cur.mode)
				utf7sd_pkg::MODE_DIRECT: begin
					res.valid  = 1'b1;
					res.status = utf7sd_pkg::ST_END;
				end
				utf7sd_pkg::MODE_PLUS: begin
					res.valid  = 1'b1;
					res.status = utf7sd_pkg::ST_INCOMPLETE;
				end
				utf7sd_pkg::MODE_SHIFT: begin
					res.valid  = 1'b1;
					res.status = cur_bad ? utf7sd_pkg::ST_MALFORMED : utf7sd_pkg::ST_END;
				end
				utf7sd_pkg::MODE_ERROR: begin
					res.valid = 1'b0;
				end
			endcase
		end else begin
			unique case (cur.mode)
				utf7sd_pkg::MODE_ERROR: begin
					res.valid = 1'b0;
				end
				utf7sd_pkg::MODE_DIRECT: begin
					dir_go = 1'b1;
				end
				utf7sd_pkg::MODE_PLUS: begin
					if (text_byte == utf7sd_pkg::CH_MINUS || text_byte == utf7sd_pkg::CH_PLUS) begin
						nxt.mode       = utf7sd_pkg::MODE_DIRECT;
						res.valid      = 1'b1;
						res.code_point = utf7sd_pkg::CP_W'(utf7sd_pkg::CH_PLUS);
					end else begin
						shf_go = 1'b1;
					end
				end
				utf7sd_pkg::MODE_SHIFT: begin
					shf_go = 1'b1;
				end
			endcase

			if (shf_go) begin
				nxt = base;
				if (!sx.ok) begin
					if (run_bad) begin
						nxt        = utf7sd_pkg::STATE_RESET;
						nxt.mode   = utf7sd_pkg::MODE_ERROR;
						res.valid  = 1'b1;
						res.status = utf7sd_pkg::ST_MALFORMED;
					end else begin
						nxt.bit_buffer   = '0;
						nxt.bit_count    = '0;
						nxt.sextet_count = '0;
						nxt.mode         = utf7sd_pkg::MODE_DIRECT;
						dir_go           = (text_byte != utf7sd_pkg::CH_MINUS);
					end
				end else begin
					nxt.mode = utf7sd_pkg::MODE_SHIFT;
					if (base.sextet_count < 2'd3) begin
						nxt.sextet_count = base.sextet_count + 2'd1;
					end
					if (full) begin
						nxt.bit_count  = rem;
						nxt.bit_buffer = acc[utf7sd_pkg::BUF_W-1:0] & mask;
						if (base.high_surrogate != '0) begin
							if (unit < utf7sd_pkg::LO_SURR_MIN || unit > utf7sd_pkg::LO_SURR_MAX) begin
								nxt        = utf7sd_pkg::STATE_RESET;
								nxt.mode   = utf7sd_pkg::MODE_ERROR;
								res.valid  = 1'b1;
								res.status = utf7sd_pkg::ST_HIGH_NO_LOW;
							end else begin
								nxt.high_surrogate = '0;
								res.valid          = 1'b1;
								res.code_point     = utf7sd_pkg::SUPP_BASE +
									utf7sd_pkg::CP_W'({base.high_surrogate[9:0], unit[9:0]});
							end
						end else if (unit >= utf7sd_pkg::HI_SURR_MIN &&
								unit <= utf7sd_pkg::HI_SURR_MAX) begin
							nxt.high_surrogate = unit;
						end else if (unit >= utf7sd_pkg::LO_SURR_MIN &&
								unit <= utf7sd_pkg::LO_SURR_MAX) begin
							nxt        = utf7sd_pkg::STATE_RESET;
							nxt.mode   = utf7sd_pkg::MODE_ERROR;
							res.valid  = 1'b1;
							res.status = utf7sd_pkg::ST_LONE_LOW;
						end else begin
							res.valid      = 1'b1;
							res.code_point = utf7sd_pkg::CP_W'(unit);
						end
					end else begin
						nxt.bit_count  = cnt6[utf7sd_pkg::BCNT_W-1:0];
						nxt.bit_buffer = acc[utf7sd_pkg::BUF_W-1:0];
					end
				end
			end

			if (dir_go) begin
				if (text_byte >= utf7sd_pkg::ASCII_LIMIT) begin
					nxt        = utf7sd_pkg::STATE_RESET;
					nxt.mode   = utf7sd_pkg::MODE_ERROR;
					res.valid  = 1'b1;
					res.status = utf7sd_pkg::ST_NONASCII;
				end else if (text_byte == utf7sd_pkg::CH_PLUS) begin
					nxt.mode = utf7sd_pkg::MODE_PLUS;
				end else begin
					nxt.mode       = utf7sd_pkg::MODE_DIRECT;
					res.valid      = 1'b1;
					res.code_point = utf7sd_pkg::CP_W'(text_byte);
				end
			end
		end
	end

endmodule

// ===== rtl/utf7_stream_decoder_top.sv =====
// UTF-7 stream decoder, one byte per transaction in, at most one code point or
// status per transaction out. Each accepted byte enters an input register, is
// decoded combinationally against the running state and lands in the output
// register. A new byte is taken every cycle while the output is not stalled.
// While a result waits on a stalled output, the input register holds its byte
// and in_stall is raised.
// Depends on utf7sd_pkg and utf7sd_step.
module utf7_stream_decoder_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [utf7sd_pkg::BYTE_W-1:0]     text_byte,
	input  logic                              end_of_text,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [utf7sd_pkg::CP_W-1:0]       code_point,
	output logic [2:0]                        status
);

	logic                              valid_s1;
	logic [utf7sd_pkg::BYTE_W-1:0]     byte_s1;
	logic                              eot_s1;
	utf7sd_pkg::state_t                state_q;
	utf7sd_pkg::state_t                state_nxt;
	utf7sd_pkg::result_t               res;
	logic                              out_valid_q;
	logic [utf7sd_pkg::CP_W-1:0]       code_point_q;
	utf7sd_pkg::status_t               status_q;
	logic                              out_free;
	logic                              advance;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	utf7sd_step u_step (
		.cur         (state_q),
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.nxt         (state_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= utf7sd_pkg::STATE_RESET;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= advance && res.valid;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
		if (advance && res.valid) begin
			code_point_q <= res.code_point;
			status_q     <= res.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = code_point_q;
	assign status     = status_q;

endmodule

// ===== rtl/utf7sd_checker.sv =====
// utf7sd_checker: port-level assertions for the UTF-7 stream decoder, bound
// to utf7_stream_decoder_top. Depends on utf7sd_pkg.
module utf7sd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [utf7sd_pkg::CP_W-1:0]   code_point,
	input logic [2:0]                    status
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= utf7sd_pkg::ST_MALFORMED)
		else $error("status out of range");

	a_err_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != utf7sd_pkg::ST_CHAR) |-> code_point == '0)
		else $error("non-character transaction carries a code point");

	a_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == utf7sd_pkg::ST_CHAR) |->
		(code_point <= 21'h10FFFF && (code_point < 21'hD800 || code_point > 21'hDFFF)))
		else $error("character is not a Unicode scalar");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(code_point) && $stable(status)))
		else $error("stalled output transaction changed");

endmodule

bind utf7_stream_decoder_top utf7sd_checker u_utf7sd_checker (.*);

// ===== tb/utf7_stream_decoder_top_test.sv =====
// Self-checking testbench for the UTF-7 stream decoder: directed and random UTF-7 text,
// with an in-line decoder model whose expected code points and statuses are checked
// against every output transaction. Depends on utf7sd_pkg and utf7_stream_decoder_top.
`timescale 1ns / 100ps

module utf7_stream_decoder_top_test;

	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [utf7sd_pkg::CP_W-1:0] cp;
		utf7sd_pkg::status_t         st;
	} decoded_t;

	typedef enum int {RX_FLOW, RX_RANDOM, RX_PERIODIC, RX_CONGESTED} rx_pattern_t;
	typedef enum int {
		FLAW_NONE, FLAW_LONE_LOW, FLAW_BROKEN_PAIR, FLAW_OPEN_HIGH, FLAW_PAD_BITS, FLAW_SHORT
	} run_flaw_t;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          in_valid    = 1'b0;
	logic                          in_stall;
	logic [utf7sd_pkg::BYTE_W-1:0] text_byte   = '0;
	logic                          end_of_text = 1'b0;
	logic                          out_valid;
	logic                          out_stall   = 1'b0;
	logic [utf7sd_pkg::CP_W-1:0]   code_point;
	logic [2:0]                    status;

	decoded_t                      awaited_results[$];
	logic [utf7sd_pkg::BYTE_W-1:0] text_q[$];
	int                            fault_count = 0;
	int                            burst_left  = 0;

	// decoder model state
	utf7sd_pkg::mode_t             dec_mode;
	logic [utf7sd_pkg::BUF_W-1:0]  acc_bits;
	logic [utf7sd_pkg::BCNT_W-1:0] acc_count;
	logic [1:0]                    run_sextets;
	logic [utf7sd_pkg::UNIT_W-1:0] held_high;

	// receiver state
	rx_pattern_t       stall_pattern = RX_FLOW;
	int                pattern_left  = 0;
	int                stall_period  = 2;
	int                hold_left     = 0;
	logic              hold_request  = 1'b0;

	utf7_stream_decoder_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_point  (code_point),
		.status      (status)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int b64_value(input logic [7:0] b);
		if (b >= 8'h41 && b <= 8'h5A) return int'(b) - 8'h41;
		if (b >= 8'h61 && b <= 8'h7A) return int'(b) - 8'h61 + 26;
		if (b >= 8'h30 && b <= 8'h39) return int'(b) - 8'h30 + 52;
		if (b == utf7sd_pkg::CH_PLUS) return 62;
		if (b == 8'h2F) return 63;
		return -1;
	endfunction

	function automatic logic [7:0] b64_char(input int v);
		if (v < 26) return 8'(8'h41 + v);
		if (v < 52) return 8'(8'h61 + v - 26);
		if (v < 62) return 8'(8'h30 + v - 52);
		if (v == 62) return utf7sd_pkg::CH_PLUS;
		return 8'h2F;
	endfunction

	function automatic void reset_decoder();
		dec_mode    = utf7sd_pkg::MODE_DIRECT;
		acc_bits    = '0;
		acc_count   = '0;
		run_sextets = '0;
		held_high   = '0;
	endfunction

	function automatic void expect_result(input logic [utf7sd_pkg::CP_W-1:0] cp,
			input utf7sd_pkg::status_t st);
		decoded_t r;
		r.cp = cp;
		r.st = st;
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	function automatic void raise_error(input utf7sd_pkg::status_t st);
		reset_decoder();
		dec_mode = utf7sd_pkg::MODE_ERROR;
		expect_result('0, st);
	endfunction

	function automatic logic run_is_broken();
		return run_sextets < 2'd3 || acc_count > 4'd4 ||
			(acc_count != 0 && acc_bits != 0) || held_high != 0;
	endfunction

	function automatic void plain_byte(input logic [7:0] b);
		if (b >= utf7sd_pkg::ASCII_LIMIT) begin
			raise_error(utf7sd_pkg::ST_NONASCII);
		end else if (b == utf7sd_pkg::CH_PLUS) begin
			dec_mode = utf7sd_pkg::MODE_PLUS;
		end else begin
			dec_mode = utf7sd_pkg::MODE_DIRECT;
			expect_result(utf7sd_pkg::CP_W'(b), utf7sd_pkg::ST_CHAR);
		end
	endfunction

	function automatic void accept_unit(input logic [utf7sd_pkg::UNIT_W-1:0] u);
		logic [utf7sd_pkg::CP_W-1:0] cp;
		if (held_high != 0) begin
			if (u < utf7sd_pkg::LO_SURR_MIN || u > utf7sd_pkg::LO_SURR_MAX) begin
				raise_error(utf7sd_pkg::ST_HIGH_NO_LOW);
				return;
			end
			cp = utf7sd_pkg::SUPP_BASE +
				(utf7sd_pkg::CP_W'(held_high - utf7sd_pkg::HI_SURR_MIN) << 10) +
				utf7sd_pkg::CP_W'(u - utf7sd_pkg::LO_SURR_MIN);
			held_high = '0;
			expect_result(cp, utf7sd_pkg::ST_CHAR);
		end else if (u >= utf7sd_pkg::HI_SURR_MIN && u <= utf7sd_pkg::HI_SURR_MAX) begin
			held_high = u;
		end else if (u >= utf7sd_pkg::LO_SURR_MIN && u <= utf7sd_pkg::LO_SURR_MAX) begin
			raise_error(utf7sd_pkg::ST_LONE_LOW);
		end else begin
			expect_result(utf7sd_pkg::CP_W'(u), utf7sd_pkg::ST_CHAR);
		end
	endfunction

	function automatic void run_byte(input logic [7:0] b);
		int          v;
		int          nb;
		logic [19:0] acc;
		v = b64_value(b);
		if (v < 0) begin
			if (run_is_broken()) begin
				raise_error(utf7sd_pkg::ST_MALFORMED);
				return;
			end
			acc_bits    = '0;
			acc_count   = '0;
			run_sextets = '0;
			dec_mode    = utf7sd_pkg::MODE_DIRECT;
			if (b != utf7sd_pkg::CH_MINUS)
				plain_byte(b);
			return;
		end
		dec_mode = utf7sd_pkg::MODE_SHIFT;
		acc = {acc_bits, 6'(v)};
		nb = int'(acc_count) + 6;
		if (run_sextets != 2'd3)
			run_sextets++;
		if (nb >= 16) begin
			nb -= 16;
			acc_count = 4'(nb);
			acc_bits = 14'(acc & ((20'd1 << nb) - 20'd1));
			accept_unit(16'(acc >> nb));
		end else begin
			acc_count = 4'(nb);
			acc_bits = acc[13:0];
		end
	endfunction

	function automatic void predict_item(input logic [7:0] b, input logic eot);
		if (eot) begin
			case (dec_mode)
				utf7sd_pkg::MODE_DIRECT: expect_result('0, utf7sd_pkg::ST_END);
				utf7sd_pkg::MODE_PLUS:   expect_result('0, utf7sd_pkg::ST_INCOMPLETE);
				utf7sd_pkg::MODE_SHIFT:
					expect_result('0, run_is_broken() ? utf7sd_pkg::ST_MALFORMED :
						utf7sd_pkg::ST_END);
				default: ;
			endcase
			reset_decoder();
			return;
		end
		case (dec_mode)
			utf7sd_pkg::MODE_DIRECT: plain_byte(b);
			utf7sd_pkg::MODE_PLUS: begin
				if (b == utf7sd_pkg::CH_MINUS || b == utf7sd_pkg::CH_PLUS) begin
					dec_mode = utf7sd_pkg::MODE_DIRECT;
					expect_result(utf7sd_pkg::CP_W'(utf7sd_pkg::CH_PLUS), utf7sd_pkg::ST_CHAR);
				end else begin
					acc_bits    = '0;
					acc_count   = '0;
					run_sextets = '0;
					held_high   = '0;
					run_byte(b);
				end
			end
			utf7sd_pkg::MODE_SHIFT: run_byte(b);
			default: ;
		endcase
	endfunction

	task automatic send_item(input logic [7:0] b, input logic eot);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		text_byte   <= b;
		end_of_text <= eot;
		do @(posedge clk); while (in_stall);
		predict_item(b, eot);
	endtask

	task automatic send_end();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	function automatic logic [15:0] bmp_scalar();
		logic [15:0] u;
		u = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16'h7F)) : 16'($urandom);
		if (u >= utf7sd_pkg::HI_SURR_MIN && u <= utf7sd_pkg::LO_SURR_MAX)
			u[13] = ~u[13];
		return u;
	endfunction

	function automatic logic [7:0] closing_byte(input logic allow_minus);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 127));
		while (b64_value(c) >= 0 || (!allow_minus && c == utf7sd_pkg::CH_MINUS));
		return c;
	endfunction

	function automatic void append_run(input logic last_segment);
		logic [15:0] units[$];
		run_flaw_t   flaw;
		int          count;
		int          acc;
		int          nbits;
		logic [19:0] scalar;
		flaw = ($urandom_range(0, 7) == 0) ? run_flaw_t'($urandom_range(1, 5)) : FLAW_NONE;
		count = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0) begin
				scalar = 20'($urandom_range(0, 20'hFFFFF));
				units.insert(units.size(), utf7sd_pkg::HI_SURR_MIN + 16'(scalar >> 10));
				units.insert(units.size(), utf7sd_pkg::LO_SURR_MIN + 16'(scalar & 20'h3FF));
			end else begin
				units.insert(units.size(), bmp_scalar());
			end
		end
		case (flaw)
			FLAW_LONE_LOW:
				units.insert(units.size(),
					utf7sd_pkg::LO_SURR_MIN + 16'($urandom_range(0, 16'h3FF)));
			FLAW_BROKEN_PAIR: begin
				units.insert(units.size(),
					utf7sd_pkg::HI_SURR_MIN + 16'($urandom_range(0, 16'h3FF)));
				units.insert(units.size(), bmp_scalar());
			end
			FLAW_OPEN_HIGH:
				units.insert(units.size(),
					utf7sd_pkg::HI_SURR_MIN + 16'($urandom_range(0, 16'h3FF)));
			default: ;
		endcase
		text_q.insert(text_q.size(), utf7sd_pkg::CH_PLUS);
		acc = 0;
		nbits = 0;
		foreach (units[i]) begin
			acc = (acc << 16) | int'(units[i]);
			nbits += 16;
			while (nbits >= 6) begin
				nbits -= 6;
				text_q.insert(text_q.size(), b64_char((acc >> nbits) & 63));
			end
			acc &= (1 << nbits) - 1;
		end
		if (nbits != 0)
			text_q.insert(text_q.size(), b64_char(((acc << (6 - nbits)) |
				((flaw == FLAW_PAD_BITS) ? $urandom_range(1, (1 << (6 - nbits)) - 1) : 0)) & 63));
		else if (flaw == FLAW_PAD_BITS)
			text_q.insert(text_q.size(), b64_char($urandom_range(0, 63)));
		if (flaw == FLAW_SHORT)
			void'(text_q.pop_back());
		// an open run may be left for the end transaction to close
		if (last_segment && $urandom_range(0, 1) == 0)
			return;
		if ($urandom_range(0, 9) == 0)
			text_q.insert(text_q.size(), 8'($urandom_range(128, 255)));
		else if ($urandom_range(0, 1) == 0)
			text_q.insert(text_q.size(), utf7sd_pkg::CH_MINUS);
		else
			text_q.insert(text_q.size(), closing_byte(1'b1));
	endfunction

	function automatic void build_message();
		int         segments;
		int         pick;
		logic [7:0] c;
		text_q.delete();
		segments = $urandom_range(1, 6);
		for (int i = 0; i < segments; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 8) begin
				repeat ($urandom_range(1, 4)) begin
					c = 8'($urandom_range(0, 127));
					text_q.insert(text_q.size(),
						(c == utf7sd_pkg::CH_PLUS) ? utf7sd_pkg::CH_MINUS : c);
				end
			end else if (pick < 10) begin
				text_q.insert(text_q.size(), utf7sd_pkg::CH_PLUS);
				pick = $urandom_range(0, 9);
				if (pick == 0 && i == segments - 1)
					;
				else if (pick == 1)
					text_q.insert(text_q.size(), closing_byte(1'b0));
				else
					text_q.insert(text_q.size(),
						(pick < 6) ? utf7sd_pkg::CH_MINUS : utf7sd_pkg::CH_PLUS);
			end else if (pick < 18) begin
				append_run(i == segments - 1);
			end else begin
				repeat ($urandom_range(1, 3))
					text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
			end
		end
	endfunction

	task automatic test_direct_bytes();
		send_item(8'h00, 1'b0);
		send_item(8'h7F, 1'b0);
		send_item(utf7sd_pkg::CH_PLUS, 1'b0);
		send_item(utf7sd_pkg::CH_MINUS, 1'b0);
		send_item(utf7sd_pkg::CH_PLUS, 1'b0);
		send_item(utf7sd_pkg::CH_PLUS, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'hFF, 1'b0);
		send_end();
	endtask

	task automatic test_incomplete_shift();
		send_item(utf7sd_pkg::CH_PLUS, 1'b0);
		send_end();
	endtask

	task automatic test_empty_shift();
		send_item(utf7sd_pkg::CH_PLUS, 1'b0);
		send_item(8'h80, 1'b0);
		send_end();
	endtask

	task automatic test_surrogate_pair();
		send_item(utf7sd_pkg::CH_PLUS, 1'b0);
		send_item(8'h32, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(8'h44, 1'b0);
		send_item(8'h63, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(8'hFF, 1'b0);
		send_end();
	endtask

	task automatic test_end_in_run();
		send_item(utf7sd_pkg::CH_PLUS, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(8'h47, 1'b0);
		send_item(8'h45, 1'b0);
		send_end();
	endtask

	task automatic test_random_text(input int item_goal);
		int sent;
		sent = 0;
		while (sent < item_goal) begin
			build_message();
			foreach (text_q[i])
				send_item(text_q[i], 1'b0);
			send_end();
			sent += text_q.size() + 1;
		end
	endtask

	task automatic test_backpressure();
		hold_request = 1'b1;
		repeat (40)
			send_item(8'($urandom_range(32, 42)), 1'b0);
		send_end();
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_left    = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (pattern_left == 0) begin
			stall_pattern = rx_pattern_t'($urandom_range(0, 3));
			pattern_left  = $urandom_range(16, 96);
			stall_period  = $urandom_range(2, 9);
		end
		pattern_left--;
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (stall_pattern)
				RX_FLOW:     out_stall <= 1'b0;
				RX_RANDOM:   out_stall <= ($urandom_range(0, 1) == 1);
				RX_PERIODIC: out_stall <= (pattern_left % stall_period) < (stall_period / 2);
				default:     out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin : result_check
		decoded_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				fault_count++;
				$display("%0t: expected no transaction, got code_point %h status %0d",
					$time, code_point, status);
			end else begin
				want = awaited_results.pop_front();
				if (code_point !== want.cp || status !== want.st) begin
					fault_count++;
					$display("%0t: expected code_point %h status %0d, got %h status %0d",
						$time, want.cp, want.st, code_point, status);
				end
			end
		end
	end

	initial begin
		reset_decoder();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_direct_bytes();
		test_incomplete_shift();
		test_empty_shift();
		test_surrogate_pair();
		test_end_in_run();
		test_random_text(1660);
		test_backpressure();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
